/* hw/rtl/smsc_pkg.sv */
package smsc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int CNT_W      = 7;
    localparam int THR_W      = 31;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER_U   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_V   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_U   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_V   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR = 3'd4;

    localparam logic [CNT_W-1:0] LINEAR_ORDER = 7'd2;

    typedef struct packed {
        logic [CNT_W-1:0] order_u;
        logic [CNT_W-1:0] order_v;
        logic [CNT_W-1:0] count_u;
        logic [CNT_W-1:0] count_v;
        logic [THR_W-1:0] noise_threshold;
    } cfg_t;

    // control of the difference stage for the word it holds
    typedef struct packed {
        logic adv;
        logic last;
        logic col_nz;
        logic row_nz;
    } stage_ctrl_t;

endpackage

/* hw/rtl/smsc_line_buf.sv */
module smsc_line_buf
    import smsc_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // same-cycle write to the address being read is forwarded
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

/* hw/rtl/smsc_diff_track.sv */
module smsc_diff_track
    import smsc_pkg::*;
#(
    parameter int COEF_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stage_ctrl_t                  ctrl,
    input  logic signed [COEF_WIDTH-1:0] coef,
    input  logic signed [COEF_WIDTH-1:0] above,
    output logic signed [COEF_WIDTH:0]   fin_min_u,
    output logic signed [COEF_WIDTH:0]   fin_max_u,
    output logic signed [COEF_WIDTH:0]   fin_min_v,
    output logic signed [COEF_WIDTH:0]   fin_max_v
);

    localparam int DW = COEF_WIDTH + 1;
    localparam logic signed [DW-1:0] TOP_POS = {1'b0, {COEF_WIDTH{1'b1}}};
    localparam logic signed [DW-1:0] TOP_NEG = {1'b1, {COEF_WIDTH{1'b0}}};

    logic signed [COEF_WIDTH-1:0] prev_reg;
    logic signed [DW-1:0] min_u_reg, max_u_reg, min_v_reg, max_v_reg;
    logic signed [DW-1:0] min_u_next, max_u_next, min_v_next, max_v_next;
    logic signed [DW-1:0] fin_min_u_reg, fin_max_u_reg, fin_min_v_reg, fin_max_v_reg;
    logic signed [DW-1:0] du, dv;

    assign du = DW'(coef) - DW'(prev_reg);
    assign dv = DW'(coef) - DW'(above);

    always_comb
    begin
        min_u_next = (ctrl.col_nz && (du < min_u_reg)) ? du : min_u_reg;
        max_u_next = (ctrl.col_nz && (du > max_u_reg)) ? du : max_u_reg;
        min_v_next = (ctrl.row_nz && (dv < min_v_reg)) ? dv : min_v_reg;
        max_v_next = (ctrl.row_nz && (dv > max_v_reg)) ? dv : max_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            min_u_reg     <= TOP_POS;
            max_u_reg     <= TOP_NEG;
            min_v_reg     <= TOP_POS;
            max_v_reg     <= TOP_NEG;
            fin_min_u_reg <= TOP_POS;
            fin_max_u_reg <= TOP_NEG;
            fin_min_v_reg <= TOP_POS;
            fin_max_v_reg <= TOP_NEG;
        end
        else if (ctrl.adv)
        begin
            prev_reg <= coef;
            if (ctrl.last)
            begin
                // snapshot for the decision, then start the next surface clean
                fin_min_u_reg <= min_u_next;
                fin_max_u_reg <= max_u_next;
                fin_min_v_reg <= min_v_next;
                fin_max_v_reg <= max_v_next;
                min_u_reg     <= TOP_POS;
                max_u_reg     <= TOP_NEG;
                min_v_reg     <= TOP_POS;
                max_v_reg     <= TOP_NEG;
            end
            else
            begin
                min_u_reg <= min_u_next;
                max_u_reg <= max_u_next;
                min_v_reg <= min_v_next;
                max_v_reg <= max_v_next;
            end
        end
    end

    assign fin_min_u = fin_min_u_reg;
    assign fin_max_u = fin_max_u_reg;
    assign fin_min_v = fin_min_v_reg;
    assign fin_max_v = fin_max_v_reg;

endmodule

/* hw/rtl/smsc_decide.sv */
module smsc_decide
    import smsc_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int CU_W       = 7,
    parameter int CV_W       = 7
) (
    input  logic                       clk,
    input  logic                       load,
    input  cfg_t                       cfg,
    input  logic [CU_W-1:0]            cu,
    input  logic [CV_W-1:0]            cv,
    input  logic signed [COEF_WIDTH:0] min_u,
    input  logic signed [COEF_WIDTH:0] max_u,
    input  logic signed [COEF_WIDTH:0] min_v,
    input  logic signed [COEF_WIDTH:0] max_v,
    output logic                       flag
);

    localparam int DW = COEF_WIDTH + 1;

    logic flag_reg;
    logic flag_next;
    logic signed [DW-1:0] a, b, c, d;
    logic lin, bez;

    function automatic logic signed [DW-1:0] denoise(
        input logic signed [DW-1:0] x,
        input logic [THR_W-1:0]     thr
    );
        logic [DW-1:0] mag;
        mag = x[DW-1] ? DW'(-x) : DW'(x);
        return (64'(mag) < 64'(thr)) ? '0 : x;
    endfunction

    function automatic logic not_opposite(
        input logic signed [DW-1:0] p,
        input logic signed [DW-1:0] q
    );
        logic pz, qz;
        pz = (p == '0);
        qz = (q == '0);
        return (!p[DW-1] && !q[DW-1]) || ((p[DW-1] || pz) && (q[DW-1] || qz));
    endfunction

    function automatic logic same_strict(
        input logic signed [DW-1:0] p,
        input logic signed [DW-1:0] q
    );
        logic pp, qp;
        pp = !p[DW-1] && (p != '0);
        qp = !q[DW-1] && (q != '0);
        return (pp && qp) || (p[DW-1] && q[DW-1]);
    endfunction

    always_comb
    begin
        a   = denoise(min_u, cfg.noise_threshold);
        b   = denoise(max_u, cfg.noise_threshold);
        c   = denoise(min_v, cfg.noise_threshold);
        d   = denoise(max_v, cfg.noise_threshold);
        lin = ((cfg.order_u == LINEAR_ORDER) && (32'(cu) == 32'd2))
           || ((cfg.order_v == LINEAR_ORDER) && (32'(cv) == 32'd2));
        bez = (32'(cfg.order_u) == 32'(cu)) && (32'(cfg.order_v) == 32'(cv));
        priority if (lin)
        begin
            flag_next = 1'b1;
        end
        else if (bez && (not_opposite(a, b) || not_opposite(c, d)))
        begin
            flag_next = 1'b1;
        end
        else if (same_strict(a, b) || same_strict(c, d))
        begin
            flag_next = 1'b1;
        end
        else
        begin
            flag_next = (a == b) || (c == d);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flag_reg <= flag_next;
        end
    end

    assign flag = flag_reg;

endmodule

/* hw/rtl/surface_monotone_simple_case_check.sv */
// The last word of a surface passes the difference stage, then the registered decision.
// Throughput: one coefficient word per cycle while the decision stage can take the last
// word; line buffer: one write, one registered read per cycle, same-address forwarding.
// Reset (rst_n, async, active low): config returns to orders 2, counts 2, threshold 0;
// position and extrema clear, pipeline empties. Line buffer contents are not cleared.
module surface_monotone_simple_case_check
    import smsc_pkg::*;
#(
    parameter int MAX_ROW_LEN = 64,
    parameter int MAX_ROWS    = 64,
    parameter int COEF_WIDTH  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COEF_WIDTH-1:0] coef_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         simple_case
);

    localparam int COL_W = $clog2(MAX_ROW_LEN);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CU_W  = $clog2(MAX_ROW_LEN + 1);
    localparam int CV_W  = $clog2(MAX_ROWS + 1);

    cfg_t cfg_reg;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CU_W-1:0]  cu;
    logic [CV_W-1:0]  cv;
    logic             row_end, surf_end;

    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic                         s1_col_nz_reg;
    logic                         s1_row_nz_reg;
    logic [COL_W-1:0]             s1_col_reg;
    logic signed [COEF_WIDTH-1:0] s1_coef_reg;
    logic                         s2_valid_reg;
    logic                         out_valid_reg;

    logic in_acc, s1_adv, s2_free, out_load;
    stage_ctrl_t s1_ctrl;

    logic signed [COEF_WIDTH-1:0] above;
    logic signed [COEF_WIDTH:0]   fin_min_u, fin_max_u, fin_min_v, fin_max_v;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order_u         <= 7'd2;
            cfg_reg.order_v         <= 7'd2;
            cfg_reg.count_u         <= 7'd2;
            cfg_reg.count_v         <= 7'd2;
            cfg_reg.noise_threshold <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ORDER_U:   cfg_reg.order_u         <= cfg_data[CNT_W-1:0];
                REG_ORDER_V:   cfg_reg.order_v         <= cfg_data[CNT_W-1:0];
                REG_COUNT_U:   cfg_reg.count_u         <= cfg_data[CNT_W-1:0];
                REG_COUNT_V:   cfg_reg.count_v         <= cfg_data[CNT_W-1:0];
                REG_NOISE_THR: cfg_reg.noise_threshold <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective counts: zero acts as one, large values saturate
    always_comb
    begin
        if (cfg_reg.count_u == '0)
            cu = CU_W'(1);
        else if (32'(cfg_reg.count_u) > 32'(MAX_ROW_LEN))
            cu = CU_W'(MAX_ROW_LEN);
        else
            cu = CU_W'(cfg_reg.count_u);

        if (cfg_reg.count_v == '0)
            cv = CV_W'(1);
        else if (32'(cfg_reg.count_v) > 32'(MAX_ROWS))
            cv = CV_W'(MAX_ROWS);
        else
            cv = CV_W'(cfg_reg.count_v);
    end

    // handshake chain: input -> difference stage -> decision -> output register
    assign out_load = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_free  = !s2_valid_reg || out_load;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || s2_free);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_acc   = in_valid && in_ready;

    // position in the surface, tracked at accept
    always_comb
    begin
        row_end  = (32'(col_reg) + 32'd1) >= 32'(cu);
        surf_end = row_end && ((32'(row_reg) + 32'd1) >= 32'(cv));
        col_next = row_end ? '0 : COL_W'(32'(col_reg) + 32'd1);
        if (surf_end)
            row_next = '0;
        else if (row_end)
            row_next = ROW_W'(32'(row_reg) + 32'd1);
        else
            row_next = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
            s1_col_nz_reg <= 1'b0;
            s1_row_nz_reg <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_reg       <= col_next;
                row_reg       <= row_next;
                s1_valid_reg  <= 1'b1;
                s1_last_reg   <= surf_end;
                s1_col_nz_reg <= (col_reg != '0);
                s1_row_nz_reg <= (row_reg != '0);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv && s1_last_reg)
                s2_valid_reg <= 1'b1;
            else if (out_load)
                s2_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_col_reg  <= col_reg;
            s1_coef_reg <= coef_value;
        end
    end

    assign s1_ctrl.adv    = s1_adv;
    assign s1_ctrl.last   = s1_last_reg;
    assign s1_ctrl.col_nz = s1_col_nz_reg;
    assign s1_ctrl.row_nz = s1_row_nz_reg;

    smsc_line_buf #(
        .DEPTH (MAX_ROW_LEN),
        .WIDTH (COEF_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (s1_coef_reg),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (above)
    );

    smsc_diff_track #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_diff_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (s1_ctrl),
        .coef      (s1_coef_reg),
        .above     (above),
        .fin_min_u (fin_min_u),
        .fin_max_u (fin_max_u),
        .fin_min_v (fin_min_v),
        .fin_max_v (fin_max_v)
    );

    smsc_decide #(
        .COEF_WIDTH (COEF_WIDTH),
        .CU_W       (CU_W),
        .CV_W       (CV_W)
    ) u_decide (
        .clk   (clk),
        .load  (out_load),
        .cfg   (cfg_reg),
        .cu    (cu),
        .cv    (cv),
        .min_u (fin_min_u),
        .max_u (fin_max_u),
        .min_v (fin_min_v),
        .max_v (fin_max_v),
        .flag  (simple_case)
    );

    assign out_valid = out_valid_reg;

endmodule
